// ===== hdl/pfla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-of-two free-list allocator package
// Shared widths, reset values, codes and word types of the allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    // Field widths.
    localparam int START_W    = 24;
    localparam int LEN_W      = 25;
    localparam int SUM_W      = 26;
    localparam int ALIGN_W    = 9;
    localparam int HSTART_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int STATUS_W   = 2;
    localparam int SOURCE_W   = 2;

    // Defaults for the top-level parameters.
    localparam int HEAP_BYTES_DEF = 16777216;
    localparam int FREE_SLOTS_DEF = 32;

    // Register reset values.
    localparam logic [ALIGN_W-1:0]  ALIGN_RESET  = 9'd16;
    localparam logic [HSTART_W-1:0] HSTART_RESET = 13'd64;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HSTART = 2'd1;

    // Request modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIST_FULL = 2'd3;

    // Result source codes.
    localparam logic [SOURCE_W-1:0] SRC_EXACT = 2'd0;
    localparam logic [SOURCE_W-1:0] SRC_SPLIT = 2'd1;
    localparam logic [SOURCE_W-1:0] SRC_BUMP  = 2'd2;
    localparam logic [SOURCE_W-1:0] SRC_NONE  = 2'd3;

    // One request word.
    typedef struct packed {
        logic               mode;
        logic [LEN_W-1:0]   request_size;
        logic [START_W-1:0] free_begin;
        logic [LEN_W-1:0]   free_size;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  region_begin;
        logic [LEN_W-1:0]    region_size;
        logic [SOURCE_W-1:0] source;
        logic [LEN_W-1:0]    heap_end;
    } result_t;

endpackage

// ===== hdl/pfla_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator channel interfaces
// Valid/ready channels for configuration writes, requests and results.
// ----------------------------------------------------------------------------

// Configuration write channel.
interface pfla_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pfla_pkg::CFG_IDX_W-1:0]   index;
    logic [pfla_pkg::CFG_DATA_W-1:0]  data;

    modport src (output valid, index, data, input ready);
    modport snk (input valid, index, data, output ready);
endinterface

// Request channel.
interface pfla_req_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [pfla_pkg::LEN_W-1:0]     request_size;
    logic [pfla_pkg::START_W-1:0]   free_begin;
    logic [pfla_pkg::LEN_W-1:0]     free_size;

    modport src (output valid, mode, request_size, free_begin, free_size, input ready);
    modport snk (input valid, mode, request_size, free_begin, free_size, output ready);
endinterface

// Result channel.
interface pfla_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [pfla_pkg::STATUS_W-1:0]   status;
    logic [pfla_pkg::START_W-1:0]    region_begin;
    logic [pfla_pkg::LEN_W-1:0]      region_size;
    logic [pfla_pkg::SOURCE_W-1:0]   source;
    logic [pfla_pkg::LEN_W-1:0]      heap_end;

    modport src (output valid, status, region_begin, region_size, source, heap_end,
                 input ready);
    modport snk (input valid, status, region_begin, region_size, source, heap_end,
                 output ready);
endinterface

// ===== hdl/pfla_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation size rounding unit
// Finds the next power of two one doubling per cycle, keeping its remainder
// modulo the alignment alongside, then pads up to the alignment.
// ----------------------------------------------------------------------------
module pfla_round (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pfla_pkg::LEN_W-1:0]     req,
    input  logic [pfla_pkg::ALIGN_W-1:0]   align,
    output logic                           done,
    output logic [pfla_pkg::SUM_W-1:0]     size
);

    typedef enum logic [1:0] {
        RND_IDLE = 2'b01,
        RND_STEP = 2'b10
    } rnd_state_t;

    rnd_state_t                    state_reg, state_next;
    logic [pfla_pkg::LEN_W-1:0]    req_reg, req_next;
    logic [pfla_pkg::SUM_W-1:0]    p_reg, p_next;
    logic [pfla_pkg::ALIGN_W-1:0]  r_reg, r_next;
    logic [pfla_pkg::SUM_W-1:0]    size_reg, size_next;
    logic                          done_reg, done_next;
    logic [pfla_pkg::ALIGN_W-1:0]  a_eff;
    logic [pfla_pkg::ALIGN_W:0]    r_dbl;

    // A zero alignment behaves as one.
    assign a_eff = (align == '0) ? pfla_pkg::ALIGN_W'(1) : align;
    assign r_dbl = {r_reg, 1'b0};

    // Doubling sequencer.
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        size_next  = size_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            RND_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    p_next     = pfla_pkg::SUM_W'(1);
                    r_next     = (a_eff == pfla_pkg::ALIGN_W'(1)) ? '0
                                                                 : pfla_pkg::ALIGN_W'(1);
                    state_next = RND_STEP;
                end
            end
            RND_STEP:
            begin
                if (p_reg < pfla_pkg::SUM_W'(req_reg))
                begin
                    p_next = {p_reg[pfla_pkg::SUM_W-2:0], 1'b0};
                    if (r_dbl >= {1'b0, a_eff})
                    begin
                        r_next = pfla_pkg::ALIGN_W'(r_dbl - {1'b0, a_eff});
                    end
                    else
                    begin
                        r_next = r_dbl[pfla_pkg::ALIGN_W-1:0];
                    end
                end
                else
                begin
                    // Pad the power of two up to the next multiple of the alignment.
                    if (r_reg == '0)
                    begin
                        size_next = p_reg;
                    end
                    else
                    begin
                        size_next = p_reg + pfla_pkg::SUM_W'(a_eff - r_reg);
                    end
                    done_next  = 1'b1;
                    state_next = RND_IDLE;
                end
            end
            default:
            begin
                state_next = RND_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RND_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Working values.
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        p_reg    <= p_next;
        r_reg    <= r_next;
        size_reg <= size_next;
    end

    assign done = done_reg;
    assign size = size_reg;

endmodule

// ===== hdl/pfla_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free list engine
// Holds the sorted free list in a single-port-write memory and walks it one
// entry per cycle to match, split, merge, remove or insert regions.
// ----------------------------------------------------------------------------
module pfla_engine #(
    parameter int HEAP_BYTES = pfla_pkg::HEAP_BYTES_DEF,
    parameter int FREE_SLOTS = pfla_pkg::FREE_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  pfla_pkg::item_t                 item,
    output logic                            idle,
    input  logic                            top_load,
    input  logic [pfla_pkg::HSTART_W-1:0]   top_value,
    output logic                            rnd_start,
    input  logic                            rnd_done,
    input  logic [pfla_pkg::SUM_W-1:0]      rnd_size,
    output logic                            res_valid,
    input  logic                            res_ready,
    output pfla_pkg::result_t               result
);

    localparam int IDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int CNT_W = $clog2(FREE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(FREE_SLOTS);
    localparam logic [pfla_pkg::SUM_W-1:0] HEAP_LIMIT = pfla_pkg::SUM_W'(HEAP_BYTES);
    localparam logic [pfla_pkg::LEN_W-1:0] HEAP_MAX = pfla_pkg::LEN_W'(HEAP_BYTES);
    localparam logic [pfla_pkg::LEN_W-1:0] TOP_RESET =
        (pfla_pkg::LEN_W'(pfla_pkg::HSTART_RESET) > HEAP_MAX) ? HEAP_MAX
                                                              : pfla_pkg::LEN_W'(pfla_pkg::HSTART_RESET);

    typedef struct packed {
        logic [pfla_pkg::START_W-1:0] start;
        logic [pfla_pkg::LEN_W-1:0]   length;
    } entry_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ROUND  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_REMOVE = 6'b001000,
        S_INSERT = 6'b010000,
        S_DONE   = 6'b100000
    } eng_state_t;

    // Saturate a merged length to the length field.
    function automatic logic [pfla_pkg::LEN_W-1:0] sat_len(
        input logic [pfla_pkg::SUM_W-1:0] v
    );
        return v[pfla_pkg::SUM_W-1] ? '1 : v[pfla_pkg::LEN_W-1:0];
    endfunction

    // Free list storage.
    entry_t                          mem [FREE_SLOTS];
    entry_t                          rdata_reg;
    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    logic [IDX_W-1:0]                mem_raddr;
    entry_t                          mem_wdata;

    eng_state_t                      state_reg, state_next;
    logic                            mode_reg, mode_next;
    logic [pfla_pkg::START_W-1:0]    fb_reg, fb_next;
    logic [pfla_pkg::LEN_W-1:0]      fs_reg, fs_next;
    logic [pfla_pkg::LEN_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [pfla_pkg::LEN_W-1:0]      heap_top_reg, heap_top_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]                rd_idx_reg, rd_idx_next;
    logic                            best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]                best_idx_reg, best_idx_next;
    logic [pfla_pkg::START_W-1:0]    best_start_reg, best_start_next;
    logic [pfla_pkg::LEN_W-1:0]      best_len_reg, best_len_next;
    logic                            at_vld_reg, at_vld_next;
    logic [CNT_W-1:0]                at_reg, at_next;
    logic [pfla_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [pfla_pkg::START_W-1:0]    begin_reg, begin_next;
    logic [pfla_pkg::LEN_W-1:0]      size_reg, size_next;
    logic [pfla_pkg::SOURCE_W-1:0]   source_reg, source_next;

    entry_t                          ent;
    logic [pfla_pkg::SUM_W-1:0]      end_sum;
    logic [pfla_pkg::SUM_W-1:0]      fb_sum;
    logic [pfla_pkg::LEN_W-1:0]      merge_len;
    logic [pfla_pkg::SUM_W-1:0]      top_sum;
    logic [CNT_W-1:0]                rd_idx_dn;
    logic [CNT_W-1:0]                rd_idx_up;
    logic [CNT_W-1:0]                idx_dn;

    // Memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Entry arithmetic on the word just read.
    assign ent       = rdata_reg;
    assign end_sum   = pfla_pkg::SUM_W'(ent.start) + pfla_pkg::SUM_W'(ent.length);
    assign fb_sum    = pfla_pkg::SUM_W'(fb_reg) + pfla_pkg::SUM_W'(fs_reg);
    assign merge_len = sat_len(pfla_pkg::SUM_W'(ent.length) + pfla_pkg::SUM_W'(fs_reg));
    assign top_sum   = pfla_pkg::SUM_W'(heap_top_reg) + pfla_pkg::SUM_W'(n_reg);
    assign rd_idx_dn = rd_idx_reg - CNT_W'(1);
    assign rd_idx_up = rd_idx_reg + CNT_W'(1);
    assign idx_dn    = idx_reg - CNT_W'(1);

    // Request sequencer.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        fb_next         = fb_reg;
        fs_next         = fs_reg;
        n_next          = n_reg;
        count_next      = count_reg;
        heap_top_next   = heap_top_reg;
        idx_next        = idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        at_vld_next     = at_vld_reg;
        at_next         = at_reg;
        status_next     = status_reg;
        begin_next      = begin_reg;
        size_next       = size_reg;
        source_next     = source_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = ent;
        mem_raddr       = idx_reg[IDX_W-1:0];
        rnd_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next     = item.mode;
                    fb_next       = item.free_begin;
                    fs_next       = item.free_size;
                    status_next   = pfla_pkg::ST_OK;
                    begin_next    = '0;
                    size_next     = '0;
                    source_next   = pfla_pkg::SRC_NONE;
                    idx_next      = '0;
                    best_vld_next = 1'b0;
                    at_vld_next   = 1'b0;
                    if (item.mode == pfla_pkg::MODE_ALLOC)
                    begin
                        if (item.request_size == '0)
                        begin
                            status_next = pfla_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            rnd_start  = 1'b1;
                            state_next = S_ROUND;
                        end
                    end
                    else if (item.free_size == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_ROUND:
            begin
                if (rnd_done)
                begin
                    if (rnd_size > HEAP_LIMIT)
                    begin
                        status_next = pfla_pkg::ST_NO_SPACE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        n_next     = rnd_size[pfla_pkg::LEN_W-1:0];
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read while entries remain.
                if (idx_reg < count_reg)
                begin
                    mem_raddr   = idx_reg[IDX_W-1:0];
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg;
                    idx_next    = idx_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (mode_reg == pfla_pkg::MODE_ALLOC)
                    begin
                        if (ent.length == n_reg)
                        begin
                            // Exact fit: hand it out and close the gap.
                            begin_next  = ent.start;
                            size_next   = n_reg;
                            source_next = pfla_pkg::SRC_EXACT;
                            idx_next    = rd_idx_up;
                            rd_vld_next = 1'b0;
                            state_next  = S_REMOVE;
                        end
                        else if (ent.length > n_reg &&
                                 (!best_vld_reg || ent.length < best_len_reg))
                        begin
                            best_vld_next   = 1'b1;
                            best_idx_next   = rd_idx_reg[IDX_W-1:0];
                            best_start_next = ent.start;
                            best_len_next   = ent.length;
                        end
                    end
                    else
                    begin
                        if (end_sum == pfla_pkg::SUM_W'(fb_reg))
                        begin
                            // Region ends where the freed range starts.
                            mem_we      = 1'b1;
                            mem_waddr   = rd_idx_reg[IDX_W-1:0];
                            mem_wdata   = '{start: ent.start, length: merge_len};
                            rd_vld_next = 1'b0;
                            state_next  = S_DONE;
                        end
                        else if (fb_sum == pfla_pkg::SUM_W'(ent.start))
                        begin
                            // Freed range ends where the region starts.
                            mem_we      = 1'b1;
                            mem_waddr   = rd_idx_reg[IDX_W-1:0];
                            mem_wdata   = '{start: fb_reg, length: merge_len};
                            rd_vld_next = 1'b0;
                            state_next  = S_DONE;
                        end
                        else if (!at_vld_reg && ent.start >= fb_reg)
                        begin
                            at_vld_next = 1'b1;
                            at_next     = rd_idx_reg;
                        end
                    end
                end
                else if (idx_reg == count_reg)
                begin
                    // The whole list has been seen.
                    if (mode_reg == pfla_pkg::MODE_ALLOC)
                    begin
                        if (best_vld_reg)
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = best_idx_reg;
                            mem_wdata   = '{start: best_start_reg + n_reg[pfla_pkg::START_W-1:0],
                                            length: best_len_reg - n_reg};
                            begin_next  = best_start_reg;
                            size_next   = n_reg;
                            source_next = pfla_pkg::SRC_SPLIT;
                        end
                        else if (top_sum > HEAP_LIMIT)
                        begin
                            status_next = pfla_pkg::ST_NO_SPACE;
                        end
                        else
                        begin
                            heap_top_next = top_sum[pfla_pkg::LEN_W-1:0];
                            begin_next    = heap_top_reg[pfla_pkg::START_W-1:0];
                            size_next     = n_reg;
                            source_next   = pfla_pkg::SRC_BUMP;
                        end
                        state_next = S_DONE;
                    end
                    else if (count_reg >= SLOTS_CNT)
                    begin
                        status_next = pfla_pkg::ST_LIST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        if (!at_vld_reg)
                        begin
                            at_next = count_reg;
                        end
                        idx_next   = count_reg;
                        state_next = S_INSERT;
                    end
                end
            end

            S_REMOVE:
            begin
                // Move each later entry down by one slot.
                if (idx_reg < count_reg)
                begin
                    mem_raddr   = idx_reg[IDX_W-1:0];
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg;
                    idx_next    = idx_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_dn[IDX_W-1:0];
                    mem_wdata = ent;
                end
                else if (idx_reg >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_INSERT:
            begin
                // Move entries at and above the insert point up by one slot.
                if (idx_reg > at_reg)
                begin
                    mem_raddr   = idx_dn[IDX_W-1:0];
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_dn;
                    idx_next    = idx_dn;
                end
                if (rd_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_up[IDX_W-1:0];
                    mem_wdata = ent;
                end
                else if (idx_reg == at_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = at_reg[IDX_W-1:0];
                    mem_wdata  = '{start: fb_reg, length: fs_reg};
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A heap start write reloads the heap end, clamped to capacity.
        if (top_load)
        begin
            heap_top_next = (pfla_pkg::LEN_W'(top_value) > HEAP_MAX) ? HEAP_MAX
                                                                     : pfla_pkg::LEN_W'(top_value);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            heap_top_reg <= TOP_RESET;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            heap_top_reg <= heap_top_next;
            rd_vld_reg   <= rd_vld_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        fb_reg         <= fb_next;
        fs_reg         <= fs_next;
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        rd_idx_reg     <= rd_idx_next;
        best_vld_reg   <= best_vld_next;
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        at_vld_reg     <= at_vld_next;
        at_reg         <= at_next;
        status_reg     <= status_next;
        begin_reg      <= begin_next;
        size_reg       <= size_next;
        source_reg     <= source_next;
    end

    assign idle                = (state_reg == S_IDLE);
    assign res_valid           = (state_reg == S_DONE);
    assign result.status       = status_reg;
    assign result.region_begin = begin_reg;
    assign result.region_size  = size_reg;
    assign result.source       = source_reg;
    assign result.heap_end     = heap_top_reg;

endmodule

// ===== hdl/pow2_free_list_allocator.sv =====
// A zero-size request goes straight to its result word. An allocate first rounds its size,
// then scans the list, closing the gap after an exact fit; a free scans the list and, when
// no listed region touches the freed range, opens a slot if one is left and inserts it there.
// Requests are served one at a time: the next is taken only once the result has left the engine.
// Reset empties the list and loads the heap end from the heap_start reset value.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-of-two free-list allocator
// Rounds allocation sizes, serves them from a sorted free list or by bumping
// the heap end, and merges or inserts freed regions.
// ----------------------------------------------------------------------------
module pow2_free_list_allocator #(
    parameter int HEAP_BYTES = pfla_pkg::HEAP_BYTES_DEF,
    parameter int FREE_SLOTS = pfla_pkg::FREE_SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pfla_cfg_if.snk   cfg,
    pfla_req_if.snk   req,
    pfla_rsp_if.src   rsp
);

    logic [pfla_pkg::ALIGN_W-1:0]  align_reg;
    logic                          top_load;
    logic                          eng_idle;
    logic                          eng_start;
    pfla_pkg::item_t               item;
    logic                          rnd_start;
    logic                          rnd_done;
    logic [pfla_pkg::SUM_W-1:0]    rnd_size;
    logic                          res_valid;
    logic                          res_ready;
    pfla_pkg::result_t             result;
    logic                          rsp_vld_reg;
    pfla_pkg::result_t             rsp_word_reg;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;
    assign top_load  = cfg.valid && cfg.ready && (cfg.index == pfla_pkg::CFG_HSTART);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_reg <= pfla_pkg::ALIGN_RESET;
        end
        else if (cfg.valid && cfg.ready && cfg.index == pfla_pkg::CFG_ALIGN)
        begin
            align_reg <= cfg.data[pfla_pkg::ALIGN_W-1:0];
        end
    end

    // Request intake.
    assign req.ready         = eng_idle;
    assign eng_start         = req.valid && eng_idle;
    assign item.mode         = req.mode;
    assign item.request_size = req.request_size;
    assign item.free_begin   = req.free_begin;
    assign item.free_size    = req.free_size;

    pfla_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rnd_start),
        .req   (req.request_size),
        .align (align_reg),
        .done  (rnd_done),
        .size  (rnd_size)
    );

    pfla_engine #(
        .HEAP_BYTES (HEAP_BYTES),
        .FREE_SLOTS (FREE_SLOTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eng_start),
        .item      (item),
        .idle      (eng_idle),
        .top_load  (top_load),
        .top_value (cfg.data),
        .rnd_start (rnd_start),
        .rnd_done  (rnd_done),
        .rnd_size  (rnd_size),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    // Output register parts the engine from the result channel.
    assign res_ready = !rsp_vld_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_vld_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_word_reg <= result;
        end
    end

    assign rsp.valid        = rsp_vld_reg;
    assign rsp.status       = rsp_word_reg.status;
    assign rsp.region_begin = rsp_word_reg.region_begin;
    assign rsp.region_size  = rsp_word_reg.region_size;
    assign rsp.source       = rsp_word_reg.source;
    assign rsp.heap_end     = rsp_word_reg.heap_end;

    // A bump result leaves the heap end just past the returned region.
    a_bump_end: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.source == pfla_pkg::SRC_BUMP |->
            rsp.heap_end == pfla_pkg::LEN_W'(rsp.region_begin) + rsp.region_size)
        else $error("bump result does not end at the heap end");

    // Failed or empty requests return no region.
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != pfla_pkg::ST_OK |->
            rsp.region_size == '0 && rsp.region_begin == '0 &&
            rsp.source == pfla_pkg::SRC_NONE)
        else $error("failed request returned a region");

    // The engine never takes a request while a rounding pass is running.
    a_round_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_start |=> !eng_idle && !res_valid)
        else $error("engine left the rounding wait early");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free-list allocator testbench
// Drives allocate and free words into the allocator, keeps its own copy of
// the free list and heap end to predict every result word, and compares
// the results in order. A short table of corner cases comes first, then
// phases of random traffic under several register settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int HEAP_BYTES = pfla_pkg::HEAP_BYTES_DEF;
    localparam int FREE_SLOTS = pfla_pkg::FREE_SLOTS_DEF;

    localparam longint unsigned LEN_MAX = (64'd1 << pfla_pkg::LEN_W) - 1;
    localparam int FULL_SIZE    = 1 << 24;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 115;
    localparam int FRAG_PHASE   = 2;
    localparam int FRAG_ALLOCS  = 70;
    localparam int PRESSURE_AT  = 150;
    localparam int PRESSURE_LEN = 400;
    localparam int MAX_REPORTS  = 10;

    // One block handed out by the allocator and not yet given back.
    typedef struct {
        logic [pfla_pkg::START_W-1:0] base;
        logic [pfla_pkg::LEN_W-1:0]   len;
    } block_t;

    // One row of the directed table: a register write or a request word.
    typedef struct {
        bit                              is_cfg;
        logic [pfla_pkg::CFG_IDX_W-1:0]  idx;
        logic [pfla_pkg::CFG_DATA_W-1:0] val;
        pfla_pkg::item_t                 word;
        bit                              typed;
        pfla_pkg::result_t               want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    pfla_cfg_if cfg_ch ();
    pfla_req_if req_ch ();
    pfla_rsp_if rsp_ch ();

    pow2_free_list_allocator #(
        .HEAP_BYTES (HEAP_BYTES),
        .FREE_SLOTS (FREE_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted allocator state.
    logic [pfla_pkg::START_W-1:0] list_start [FREE_SLOTS];
    logic [pfla_pkg::LEN_W-1:0]   list_len   [FREE_SLOTS];
    int                           list_count;
    longint unsigned              brk;
    logic [pfla_pkg::ALIGN_W-1:0] align_reg;

    pfla_pkg::result_t results_due [$];
    block_t            live_blocks [$];
    stim_row_t         stim_rows [$];

    int          errors = 0;
    int unsigned cycle_count = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    bit          quiet_tail = 1'b0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [pfla_pkg::LEN_W-1:0] sat_len(input longint unsigned v);
        return (v > LEN_MAX) ? pfla_pkg::LEN_W'(LEN_MAX) : pfla_pkg::LEN_W'(v);
    endfunction

    // Computes the result word of one request and updates the predicted state.
    function automatic pfla_pkg::result_t serve_request(input pfla_pkg::item_t it);
        pfla_pkg::result_t r;
        longint unsigned   n;
        longint unsigned   p;
        longint unsigned   a;
        longint unsigned   sum;
        int                hit;
        int                best;
        int                k;
        int                at;
        r = '0;
        r.status = pfla_pkg::ST_OK;
        r.source = pfla_pkg::SRC_NONE;
        if (it.mode == pfla_pkg::MODE_ALLOC)
        begin
            if (it.request_size == '0)
            begin
                r.status = pfla_pkg::ST_EMPTY;
            end
            else
            begin
                // Round up to a power of two, then to the alignment.
                a = align_reg;
                if (a == 0)
                    a = 1;
                p = 1;
                while (p < it.request_size)
                    p = p << 1;
                n = ((p + a - 1) / a) * a;
                if (n > HEAP_BYTES)
                begin
                    r.status = pfla_pkg::ST_NO_SPACE;
                end
                else
                begin
                    // First region of exactly the rounded size.
                    hit = -1;
                    for (k = 0; k < list_count; k++)
                        if (hit < 0 && list_len[k] == n)
                            hit = k;
                    if (hit >= 0)
                    begin
                        r.region_begin = list_start[hit];
                        r.region_size  = pfla_pkg::LEN_W'(n);
                        r.source       = pfla_pkg::SRC_EXACT;
                        for (k = hit; k + 1 < list_count; k++)
                        begin
                            list_start[k] = list_start[k + 1];
                            list_len[k]   = list_len[k + 1];
                        end
                        list_count--;
                    end
                    else
                    begin
                        // Smallest larger region, split from its front.
                        best = -1;
                        for (k = 0; k < list_count; k++)
                            if (list_len[k] > n && (best < 0 || list_len[k] < list_len[best]))
                                best = k;
                        if (best >= 0)
                        begin
                            r.region_begin   = list_start[best];
                            r.region_size    = pfla_pkg::LEN_W'(n);
                            r.source         = pfla_pkg::SRC_SPLIT;
                            list_start[best] = list_start[best] + pfla_pkg::START_W'(n);
                            list_len[best]   = list_len[best] - pfla_pkg::LEN_W'(n);
                        end
                        else if (brk + n > HEAP_BYTES)
                        begin
                            r.status = pfla_pkg::ST_NO_SPACE;
                        end
                        else
                        begin
                            r.region_begin = pfla_pkg::START_W'(brk);
                            r.region_size  = pfla_pkg::LEN_W'(n);
                            r.source       = pfla_pkg::SRC_BUMP;
                            brk = brk + n;
                        end
                    end
                end
            end
        end
        else if (it.free_size != '0)
        begin
            // Extend the first region that touches the freed range.
            hit = -1;
            for (k = 0; k < list_count; k++)
            begin
                if (hit < 0)
                begin
                    sum = list_start[k];
                    sum = sum + list_len[k];
                    if (sum == it.free_begin)
                    begin
                        sum = list_len[k];
                        list_len[k] = sat_len(sum + it.free_size);
                        hit = k;
                    end
                    else
                    begin
                        sum = it.free_begin;
                        sum = sum + it.free_size;
                        if (sum == list_start[k])
                        begin
                            sum = list_len[k];
                            list_start[k] = it.free_begin;
                            list_len[k]   = sat_len(sum + it.free_size);
                            hit = k;
                        end
                    end
                end
            end
            // Otherwise insert in address order, if a slot is left.
            if (hit < 0)
            begin
                if (list_count >= FREE_SLOTS)
                begin
                    r.status = pfla_pkg::ST_LIST_FULL;
                end
                else
                begin
                    at = 0;
                    while (at < list_count && list_start[at] < it.free_begin)
                        at++;
                    for (k = list_count; k > at; k--)
                    begin
                        list_start[k] = list_start[k - 1];
                        list_len[k]   = list_len[k - 1];
                    end
                    list_start[at] = it.free_begin;
                    list_len[at]   = it.free_size;
                    list_count++;
                end
            end
        end
        r.heap_end = pfla_pkg::LEN_W'(brk);
        return r;
    endfunction

    function automatic void apply_reg(input logic [pfla_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [pfla_pkg::CFG_DATA_W-1:0] val);
        if (idx == pfla_pkg::CFG_ALIGN)
        begin
            align_reg = val[pfla_pkg::ALIGN_W-1:0];
        end
        else if (idx == pfla_pkg::CFG_HSTART)
        begin
            brk = val[pfla_pkg::HSTART_W-1:0];
            if (brk > HEAP_BYTES)
                brk = HEAP_BYTES;
            live_blocks.delete();
        end
    endfunction

    function automatic pfla_pkg::item_t alloc_item(input int unsigned size);
        pfla_pkg::item_t w;
        w.mode         = pfla_pkg::MODE_ALLOC;
        w.request_size = pfla_pkg::LEN_W'(size);
        w.free_begin   = pfla_pkg::START_W'($urandom);
        w.free_size    = pfla_pkg::LEN_W'($urandom_range(0, FULL_SIZE));
        return w;
    endfunction

    function automatic pfla_pkg::item_t free_item(input int unsigned fb, input int unsigned fs);
        pfla_pkg::item_t w;
        w.mode         = pfla_pkg::MODE_FREE;
        w.request_size = pfla_pkg::LEN_W'($urandom_range(0, FULL_SIZE));
        w.free_begin   = pfla_pkg::START_W'(fb);
        w.free_size    = pfla_pkg::LEN_W'(fs);
        return w;
    endfunction

    function automatic pfla_pkg::result_t outcome(
        input logic [pfla_pkg::STATUS_W-1:0] st, input int unsigned b,
        input int unsigned sz, input logic [pfla_pkg::SOURCE_W-1:0] src,
        input int unsigned he);
        pfla_pkg::result_t r;
        r.status       = st;
        r.region_begin = pfla_pkg::START_W'(b);
        r.region_size  = pfla_pkg::LEN_W'(sz);
        r.source       = src;
        r.heap_end     = pfla_pkg::LEN_W'(he);
        return r;
    endfunction

    function automatic stim_row_t req_row(input pfla_pkg::item_t w);
        stim_row_t s;
        s.is_cfg = 1'b0;
        s.idx    = pfla_pkg::CFG_ALIGN;
        s.val    = '0;
        s.word   = w;
        s.typed  = 1'b0;
        s.want   = '0;
        return s;
    endfunction

    function automatic stim_row_t chk_row(input pfla_pkg::item_t w,
                                          input pfla_pkg::result_t want);
        stim_row_t s;
        s = req_row(w);
        s.typed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    function automatic stim_row_t cfg_row(input logic [pfla_pkg::CFG_IDX_W-1:0] idx,
                                          input int unsigned val);
        stim_row_t s;
        s = req_row('0);
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.val    = pfla_pkg::CFG_DATA_W'(val);
        return s;
    endfunction

    // Mostly well-formed traffic: small allocations and frees of live blocks.
    function automatic pfla_pkg::item_t pick_word();
        int              r;
        int              idx;
        block_t          blk;
        pfla_pkg::item_t w;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            if ($urandom_range(0, 99) < 80)
                w = alloc_item($urandom_range(1, 64));
            else if ($urandom_range(0, 9) == 0)
                w = alloc_item($urandom_range(1, FULL_SIZE));
            else
                w = alloc_item($urandom_range(65, 4096));
        end
        else if (r < 85 && live_blocks.size() > 0)
        begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[idx];
            live_blocks.delete(idx);
            w = free_item(blk.base, blk.len);
        end
        else
        begin
            // Noise: zero sizes, near-full-heap requests and stray frees.
            case ($urandom_range(0, 4))
                0: w = alloc_item(0);
                1: w = alloc_item($urandom_range(FULL_SIZE - 64, FULL_SIZE));
                2: w = free_item($urandom, $urandom_range(0, FULL_SIZE));
                3: w = free_item($urandom, $urandom_range(1, 256));
                default: w = free_item($urandom, 0);
            endcase
        end
        return w;
    endfunction

    // Offers one request word and waits until it is taken.
    task automatic send_word(input pfla_pkg::item_t w, input bit typed,
                             input pfla_pkg::result_t want);
        pfla_pkg::result_t r;
        block_t            blk;
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= w.mode;
        req_ch.request_size <= w.request_size;
        req_ch.free_begin   <= w.free_begin;
        req_ch.free_size    <= w.free_size;
        do
            @(posedge clk);
        while (!req_ch.ready);
        r = serve_request(w);
        results_due = {results_due, (typed ? want : r)};
        if (r.status == pfla_pkg::ST_OK && r.region_size != '0)
        begin
            blk.base = r.region_begin;
            blk.len  = r.region_size;
            live_blocks = {live_blocks, blk};
        end
    endtask

    // Writes one register; the caller lowers valid after the last write.
    task automatic write_reg(input logic [pfla_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pfla_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_reg(idx, val);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    task automatic idle_gap();
        if (!quiet_tail && $urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Result receiver: random stall bursts and one long hold-off.
    initial
    begin
        int stall_left;
        int taken;
        bit pressed;
        stall_left = 0;
        taken = 0;
        pressed = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                taken++;
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!pressed && taken >= PRESSURE_AT)
            begin
                pressed = 1'b1;
                stall_left = PRESSURE_LEN - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < sink_idle_pct)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted word against the oldest prediction.
    always @(posedge clk)
    begin
        pfla_pkg::result_t got;
        pfla_pkg::result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status       = rsp_ch.status;
            got.region_begin = rsp_ch.region_begin;
            got.region_size  = rsp_ch.region_size;
            got.source       = rsp_ch.source;
            got.heap_end     = rsp_ch.heap_end;
            if (results_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result word: st=%0d begin=%h size=%h src=%0d end=%h",
                             got.status, got.region_begin, got.region_size, got.source,
                             got.heap_end);
            end
            else
            begin
                want = results_due.pop_front();
                if (got.status !== want.status || got.region_begin !== want.region_begin ||
                    got.region_size !== want.region_size || got.source !== want.source ||
                    got.heap_end !== want.heap_end)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result mismatch: want st=%0d begin=%h size=%h src=%0d end=%h, %s",
                                 want.status, want.region_begin, want.region_size, want.source,
                                 want.heap_end,
                                 $sformatf("got st=%0d begin=%h size=%h src=%0d end=%h",
                                           got.status, got.region_begin, got.region_size,
                                           got.source, got.heap_end));
                end
            end
        end
    end

    // Stimulus.
    initial
    begin
        int          i;
        int          ph;
        int          k;
        int unsigned a_val;
        int unsigned h_val;
        block_t      snap [$];

        req_ch.valid        <= 1'b0;
        req_ch.mode         <= pfla_pkg::MODE_ALLOC;
        req_ch.request_size <= '0;
        req_ch.free_begin   <= '0;
        req_ch.free_size    <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= pfla_pkg::CFG_ALIGN;
        cfg_ch.data         <= '0;
        rst_n               <= 1'b0;

        align_reg  = pfla_pkg::ALIGN_RESET;
        brk        = pfla_pkg::HSTART_RESET;
        list_count = 0;

        // Corner cases right after reset, with the results read off directly.
        stim_rows = {stim_rows, chk_row(alloc_item(0),
            outcome(pfla_pkg::ST_EMPTY, 0, 0, pfla_pkg::SRC_NONE, pfla_pkg::HSTART_RESET))};
        stim_rows = {stim_rows, chk_row(alloc_item(1),
            outcome(pfla_pkg::ST_OK, pfla_pkg::HSTART_RESET, pfla_pkg::ALIGN_RESET,
                    pfla_pkg::SRC_BUMP, pfla_pkg::HSTART_RESET + pfla_pkg::ALIGN_RESET))};
        stim_rows = {stim_rows, chk_row(alloc_item(FULL_SIZE),
            outcome(pfla_pkg::ST_NO_SPACE, 0, 0, pfla_pkg::SRC_NONE,
                    pfla_pkg::HSTART_RESET + pfla_pkg::ALIGN_RESET))};
        stim_rows = {stim_rows, chk_row(free_item(0, 0),
            outcome(pfla_pkg::ST_OK, 0, 0, pfla_pkg::SRC_NONE,
                    pfla_pkg::HSTART_RESET + pfla_pkg::ALIGN_RESET))};
        stim_rows = {stim_rows, chk_row(free_item(pfla_pkg::HSTART_RESET, pfla_pkg::ALIGN_RESET),
            outcome(pfla_pkg::ST_OK, 0, 0, pfla_pkg::SRC_NONE,
                    pfla_pkg::HSTART_RESET + pfla_pkg::ALIGN_RESET))};
        stim_rows = {stim_rows, chk_row(alloc_item(16),
            outcome(pfla_pkg::ST_OK, pfla_pkg::HSTART_RESET, pfla_pkg::ALIGN_RESET,
                    pfla_pkg::SRC_EXACT, pfla_pkg::HSTART_RESET + pfla_pkg::ALIGN_RESET))};
        // Split whose new start wraps, front and back merges up to full length.
        stim_rows = {stim_rows, req_row(free_item(24'hFFFFF0, FULL_SIZE))};
        stim_rows = {stim_rows, req_row(alloc_item(16))};
        stim_rows = {stim_rows, req_row(alloc_item(17))};
        stim_rows = {stim_rows, req_row(free_item(0, 32))};
        stim_rows = {stim_rows, req_row(free_item(24'hFFFFF0, FULL_SIZE))};
        stim_rows = {stim_rows, req_row(alloc_item(FULL_SIZE))};
        stim_rows = {stim_rows, req_row(free_item(24'h002000, 64))};
        // Zero, odd and largest alignment.
        stim_rows = {stim_rows, cfg_row(pfla_pkg::CFG_ALIGN, 0)};
        stim_rows = {stim_rows, req_row(alloc_item(5))};
        stim_rows = {stim_rows, cfg_row(pfla_pkg::CFG_ALIGN, 3)};
        stim_rows = {stim_rows, req_row(alloc_item(5))};
        stim_rows = {stim_rows, cfg_row(pfla_pkg::CFG_ALIGN, 256)};
        stim_rows = {stim_rows, req_row(alloc_item(1))};
        // Heap start extremes; the last bump fills the heap exactly.
        stim_rows = {stim_rows, cfg_row(pfla_pkg::CFG_HSTART, 4096)};
        stim_rows = {stim_rows, req_row(alloc_item(FULL_SIZE))};
        stim_rows = {stim_rows, cfg_row(pfla_pkg::CFG_HSTART, 0)};
        stim_rows = {stim_rows, cfg_row(pfla_pkg::CFG_ALIGN, 16)};
        stim_rows = {stim_rows, req_row(alloc_item(FULL_SIZE - 1))};
        stim_rows = {stim_rows, req_row(alloc_item(1))};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct  = 20;
        sink_idle_pct = 20;
        for (i = 0; i < stim_rows.size(); i++)
        begin
            if (stim_rows[i].is_cfg)
            begin
                req_ch.valid <= 1'b0;
                wait_drained();
                write_reg(stim_rows[i].idx, stim_rows[i].val);
                cfg_ch.valid <= 1'b0;
            end
            else
            begin
                idle_gap();
                send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);
            end
        end

        // Random phases, each under its own register setting.
        for (ph = 0; ph < PHASES; ph++)
        begin
            req_ch.valid <= 1'b0;
            wait_drained();
            case (ph)
                0:
                begin
                    a_val = 1;
                    h_val = 0;
                end
                1:
                begin
                    a_val = 256;
                    h_val = 4096;
                end
                FRAG_PHASE:
                begin
                    a_val = 16;
                    h_val = $urandom_range(0, 4096);
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 1)
                        a_val = 1 << $urandom_range(0, 8);
                    else
                        a_val = $urandom_range(1, 256);
                    h_val = $urandom_range(0, 4096);
                end
            endcase
            write_reg(pfla_pkg::CFG_ALIGN, pfla_pkg::CFG_DATA_W'(a_val));
            write_reg(pfla_pkg::CFG_HSTART, pfla_pkg::CFG_DATA_W'(h_val));
            cfg_ch.valid <= 1'b0;

            src_idle_pct  = (ph % 3 == 1) ? 0 : $urandom_range(10, 35);
            sink_idle_pct = (ph % 3 == 2) ? 0 : $urandom_range(10, 35);
            quiet_tail    = (ph == PHASES - 1);

            // Fragment the heap: many small blocks, every other one given back.
            if (ph == FRAG_PHASE)
            begin
                for (k = 0; k < FRAG_ALLOCS; k++)
                begin
                    idle_gap();
                    send_word(alloc_item($urandom_range(1, 16)), 1'b0, '0);
                end
                snap = live_blocks;
                live_blocks.delete();
                for (k = 0; k < snap.size(); k++)
                begin
                    if (k % 2 == 0)
                    begin
                        idle_gap();
                        send_word(free_item(snap[k].base, snap[k].len), 1'b0, '0);
                    end
                    else
                    begin
                        live_blocks = {live_blocks, snap[k]};
                    end
                end
            end

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                idle_gap();
                send_word(pick_word(), 1'b0, '0);
            end
        end

        // Drain and make sure nothing else comes out.
        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
